// ===== rtl/ibm_pkg.sv =====
// Shared types and constants for the byte-level I2C master.
// Phase codes, command codes, item and result structs, register reset values.
// No dependencies.
package ibm_pkg;

    // Command codes carried in the action field
    localparam logic [2:0] OP_NONE  = 3'd0;
    localparam logic [2:0] OP_START = 3'd1;
    localparam logic [2:0] OP_STOP  = 3'd2;
    localparam logic [2:0] OP_WRITE = 3'd3;
    localparam logic [2:0] OP_READ  = 3'd4;

    // Configuration register indexes
    localparam logic CFG_HALF_PERIOD = 1'b0;
    localparam logic CFG_ACK_WAIT    = 1'b1;

    localparam int unsigned HALF_PERIOD_W = 16;
    localparam int unsigned ACK_WAIT_W    = 8;
    localparam int unsigned CFG_DATA_W    = 16;

    localparam logic [HALF_PERIOD_W-1:0] HALF_PERIOD_RST = 16'd100;
    localparam logic [ACK_WAIT_W-1:0]    ACK_WAIT_RST    = 8'd250;

    localparam int unsigned TDATA_W = 16;

    typedef enum logic [3:0] {
        PH_IDLE      = 4'd0,
        PH_STA_A     = 4'd1,
        PH_STA_B     = 4'd2,
        PH_STA_C     = 4'd3,
        PH_STA_D     = 4'd4,
        PH_SP_A      = 4'd5,
        PH_SP_B      = 4'd6,
        PH_SP_C      = 4'd7,
        PH_BIT_LOW   = 4'd8,
        PH_BIT_HIGH  = 4'd9,
        PH_NINE_LOW  = 4'd10,
        PH_NINE_HIGH = 4'd11,
        PH_END       = 4'd12
    } phase_t;

    typedef struct packed {
        logic [2:0] action;
        logic [7:0] tx_byte;
        logic       send_nack;
        logic       sda_in;
    } item_t;

    typedef struct packed {
        logic       scl_out;
        logic       sda_out;
        logic       busy_res;
        logic       done_res;
        logic [7:0] rx_byte;
        logic       ack_missing;
    } result_t;

    typedef struct packed {
        phase_t                   phase;
        logic [2:0]               op;
        logic [3:0]               bit_index;
        logic [7:0]               shift;
        logic [HALF_PERIOD_W-1:0] tick;
        logic [ACK_WAIT_W-1:0]    ack_cnt;
        logic                     nack_req;
        logic                     scl;
        logic                     sda;
        logic [7:0]               rx_hold;
        logic                     ack_missing;
    } eng_state_t;

endpackage

// ===== rtl/ibm_engine.sv =====
// Bus sequencer of the I2C master: state registers plus one-tick update logic.
// Depends on ibm_pkg.
module ibm_engine (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 step_en,
    input  ibm_pkg::item_t                       item,
    input  logic [ibm_pkg::HALF_PERIOD_W-1:0]    half_period,
    input  logic [ibm_pkg::ACK_WAIT_W-1:0]       ack_wait,
    output ibm_pkg::result_t                     res
);

    ibm_pkg::eng_state_t st_reg;
    ibm_pkg::eng_state_t st_next;

    logic                                done;
    logic                                do_enter;
    ibm_pkg::phase_t                     enter_ph;
    logic [ibm_pkg::HALF_PERIOD_W-1:0]   tick_inc;
    logic [ibm_pkg::ACK_WAIT_W-1:0]      ack_inc;
    logic [3:0]                          bit_inc;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg.phase       <= ibm_pkg::PH_IDLE;
            st_reg.op          <= ibm_pkg::OP_NONE;
            st_reg.bit_index   <= '0;
            st_reg.shift       <= '0;
            st_reg.tick        <= '0;
            st_reg.ack_cnt     <= '0;
            st_reg.nack_req    <= 1'b0;
            st_reg.scl         <= 1'b1;
            st_reg.sda         <= 1'b1;
            st_reg.rx_hold     <= '0;
            st_reg.ack_missing <= 1'b0;
        end else if (step_en) begin
            st_reg <= st_next;
        end
    end

    always_comb begin
        st_next  = st_reg;
        done     = 1'b0;
        do_enter = 1'b0;
        enter_ph = ibm_pkg::PH_IDLE;
        tick_inc = st_reg.tick + 16'd1;
        ack_inc  = st_reg.ack_cnt + 8'd1;
        bit_inc  = st_reg.bit_index + 4'd1;

        if (st_reg.phase == ibm_pkg::PH_IDLE) begin
            if (item.action inside {[ibm_pkg::OP_START:ibm_pkg::OP_READ]}) begin
                st_next.op        = item.action;
                st_next.bit_index = '0;
                do_enter          = 1'b1;
                case (item.action)
                    ibm_pkg::OP_START: enter_ph = ibm_pkg::PH_STA_A;
                    ibm_pkg::OP_STOP:  enter_ph = ibm_pkg::PH_SP_A;
                    ibm_pkg::OP_WRITE: begin
                        st_next.shift       = item.tx_byte;
                        st_next.ack_missing = 1'b0;
                        enter_ph            = ibm_pkg::PH_BIT_LOW;
                    end
                    default: begin
                        st_next.shift    = '0;
                        st_next.nack_req = item.send_nack;
                        enter_ph         = ibm_pkg::PH_BIT_LOW;
                    end
                endcase
            end
        end else if (st_reg.phase == ibm_pkg::PH_NINE_HIGH &&
                     st_reg.op == ibm_pkg::OP_WRITE) begin
            // ACK poll: ends early on a low SDA, else after the wait limit
            if (!item.sda_in) begin
                do_enter = 1'b1;
                enter_ph = ibm_pkg::PH_END;
            end else begin
                st_next.ack_cnt = ack_inc;
                if (ack_inc >= ack_wait) begin
                    st_next.ack_missing = 1'b1;
                    do_enter            = 1'b1;
                    enter_ph            = ibm_pkg::PH_SP_A;
                end
            end
        end else begin
            st_next.tick = tick_inc;
            if (tick_inc >= half_period) begin
                do_enter = 1'b1;
                case (st_reg.phase)
                    ibm_pkg::PH_STA_A:    enter_ph = ibm_pkg::PH_STA_B;
                    ibm_pkg::PH_STA_B:    enter_ph = ibm_pkg::PH_STA_C;
                    ibm_pkg::PH_STA_C:    enter_ph = ibm_pkg::PH_STA_D;
                    ibm_pkg::PH_SP_A:     enter_ph = ibm_pkg::PH_SP_B;
                    ibm_pkg::PH_SP_B:     enter_ph = ibm_pkg::PH_SP_C;
                    ibm_pkg::PH_BIT_LOW:  enter_ph = ibm_pkg::PH_BIT_HIGH;
                    ibm_pkg::PH_BIT_HIGH: begin
                        st_next.shift = {st_reg.shift[6:0],
                                         (st_reg.op == ibm_pkg::OP_READ) & item.sda_in};
                        st_next.bit_index = bit_inc;
                        enter_ph = (bit_inc >= 4'd8) ? ibm_pkg::PH_NINE_LOW
                                                     : ibm_pkg::PH_BIT_LOW;
                    end
                    ibm_pkg::PH_NINE_LOW:  enter_ph = ibm_pkg::PH_NINE_HIGH;
                    ibm_pkg::PH_NINE_HIGH: enter_ph = ibm_pkg::PH_END;
                    default: begin
                        // last step of a command: back to idle
                        do_enter = 1'b0;
                        if (st_reg.phase == ibm_pkg::PH_END &&
                            st_reg.op == ibm_pkg::OP_READ) begin
                            st_next.rx_hold = st_reg.shift;
                        end
                        st_next.phase = ibm_pkg::PH_IDLE;
                        st_next.tick  = '0;
                        done          = 1'b1;
                    end
                endcase
            end
        end

        // line levels are set on entry to a phase
        if (do_enter) begin
            st_next.phase = enter_ph;
            st_next.tick  = '0;
            case (enter_ph)
                ibm_pkg::PH_STA_A: st_next.sda = 1'b1;
                ibm_pkg::PH_STA_B: begin st_next.scl = 1'b1; st_next.sda = 1'b1; end
                ibm_pkg::PH_STA_C: begin st_next.scl = 1'b1; st_next.sda = 1'b0; end
                ibm_pkg::PH_STA_D: begin st_next.scl = 1'b0; st_next.sda = 1'b0; end
                ibm_pkg::PH_SP_A:  begin st_next.scl = 1'b0; st_next.sda = 1'b0; end
                ibm_pkg::PH_SP_B:  begin st_next.scl = 1'b1; st_next.sda = 1'b0; end
                ibm_pkg::PH_SP_C:  begin st_next.scl = 1'b1; st_next.sda = 1'b1; end
                ibm_pkg::PH_BIT_LOW: begin
                    st_next.scl = 1'b0;
                    st_next.sda = (st_next.op == ibm_pkg::OP_WRITE) ? st_next.shift[7]
                                                                     : 1'b1;
                end
                ibm_pkg::PH_BIT_HIGH: st_next.scl = 1'b1;
                ibm_pkg::PH_NINE_LOW: begin
                    st_next.scl = 1'b0;
                    st_next.sda = (st_next.op == ibm_pkg::OP_WRITE) ? 1'b1
                                                                     : st_next.nack_req;
                end
                ibm_pkg::PH_NINE_HIGH: begin
                    st_next.scl     = 1'b1;
                    st_next.ack_cnt = '0;
                end
                ibm_pkg::PH_END: begin st_next.scl = 1'b0; st_next.sda = 1'b1; end
                default: ;
            endcase
        end

        res.scl_out     = st_next.scl;
        res.sda_out     = st_next.sda;
        res.busy_res    = (st_next.phase != ibm_pkg::PH_IDLE);
        res.done_res    = done;
        res.rx_byte     = st_next.rx_hold;
        res.ack_missing = st_next.ack_missing;
    end

`ifndef SYNTH
    a_bit_index_range: assert property (@(posedge aclk) disable iff (!aresetn)
        st_reg.phase == ibm_pkg::PH_BIT_HIGH |-> st_reg.bit_index < 4'd8)
        else $error("bit index out of range in bit high phase");

    a_done_from_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        step_en && done |-> st_reg.phase != ibm_pkg::PH_IDLE && !res.busy_res)
        else $error("done pulse without a running command");

    a_ack_poll_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        st_reg.phase == ibm_pkg::PH_NINE_HIGH && st_reg.op == ibm_pkg::OP_WRITE
        |-> st_reg.ack_cnt < ack_wait || ack_wait == '0)
        else $error("ack poll ran past the wait limit");

    a_idle_holds_lines: assert property (@(posedge aclk) disable iff (!aresetn)
        step_en && st_reg.phase == ibm_pkg::PH_IDLE && !res.busy_res
        |-> res.scl_out == st_reg.scl && res.sda_out == st_reg.sda)
        else $error("lines moved while idle");
`endif

endmodule

// ===== rtl/i2c_bitbang_master.sv =====
// Top level of the byte-level I2C master: stream ports, config registers,
// input and result registers around the bus sequencer.
// Depends on ibm_pkg and ibm_engine.
//
// An accepted item passes through the input register, one tick of logic and the
// result register before its result shows on m_tdata.
// Throughput: 1 item per cycle; s_tready drops only when both registers hold
// items and m_tready is low.
// Reset (aresetn low, synchronous): bus idle with SCL and SDA released,
// received byte and missing-ACK flag cleared, half period 100, ACK wait 250.
module i2c_bitbang_master (
    input  logic                              aclk,
    input  logic                              aresetn,
    // input items: [2:0] action, [10:3] tx_byte, [11] send_nack, [12] sda_in
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [ibm_pkg::TDATA_W-1:0]       s_tdata,
    // result items: [0] scl_out, [1] sda_out, [2] busy_res, [3] done_res,
    // [11:4] rx_byte, [12] ack_missing
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [ibm_pkg::TDATA_W-1:0]       m_tdata,
    // configuration writes: index 0 half period, index 1 ACK wait limit
    input  logic                              cfg_wr_en,
    input  logic                              cfg_index,
    input  logic [ibm_pkg::CFG_DATA_W-1:0]    cfg_data
);

    logic [ibm_pkg::HALF_PERIOD_W-1:0] half_period_reg;
    logic [ibm_pkg::ACK_WAIT_W-1:0]    ack_wait_reg;

    logic             in_valid_reg;
    ibm_pkg::item_t   in_item_reg;
    logic             out_valid_reg;
    ibm_pkg::result_t out_res_reg;

    ibm_pkg::result_t step_res;
    logic             advance;
    logic             step_en;

    // Pipeline moves whenever the result register is free or being drained
    assign advance  = !out_valid_reg || m_tready;
    assign s_tready = !in_valid_reg || advance;
    assign step_en  = in_valid_reg && advance;

    // config registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            half_period_reg <= ibm_pkg::HALF_PERIOD_RST;
            ack_wait_reg    <= ibm_pkg::ACK_WAIT_RST;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                ibm_pkg::CFG_HALF_PERIOD:
                    half_period_reg <= cfg_data[ibm_pkg::HALF_PERIOD_W-1:0];
                ibm_pkg::CFG_ACK_WAIT:
                    ack_wait_reg <= cfg_data[ibm_pkg::ACK_WAIT_W-1:0];
                default: ;
            endcase
        end
    end

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_item_reg.action    <= s_tdata[2:0];
            in_item_reg.tx_byte   <= s_tdata[10:3];
            in_item_reg.send_nack <= s_tdata[11];
            in_item_reg.sda_in    <= s_tdata[12];
        end
    end

    ibm_engine u_engine (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .step_en     (step_en),
        .item        (in_item_reg),
        .half_period (half_period_reg),
        .ack_wait    (ack_wait_reg),
        .res         (step_res)
    );

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (step_en) begin
            out_res_reg <= step_res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'b000,
                       out_res_reg.ack_missing,
                       out_res_reg.rx_byte,
                       out_res_reg.done_res,
                       out_res_reg.busy_res,
                       out_res_reg.sda_out,
                       out_res_reg.scl_out};

endmodule

// ===== tb/tb_i2c_bitbang_master.sv =====
// Self-checking testbench for the byte-level I2C master (i2c_bitbang_master).
// Streams clock-tick items, predicts every result with a cycle model of the
// bus sequencer and compares field by field. Depends on ibm_pkg and the RTL.
module tb_i2c_bitbang_master;
    import ibm_pkg::*;

    // Action codes with no command behind them; the block treats them as ticks
    localparam logic [2:0] ACT_SPARE_LO = 3'd5;
    localparam logic [2:0] ACT_SPARE_HI = 3'd7;

    // How the simulated slave answers the ACK clock of a write
    typedef enum int {ACK_NOW, ACK_LATE, ACK_NEVER} slave_ack_t;
    // What the slave puts on SDA for the other ticks of a command
    typedef enum int {SDA_LOW, SDA_HIGH, SDA_RAND} sda_drive_t;

    // Cycle model of the sequencer: one call per tick
    typedef struct {
        phase_t     ph;
        logic [2:0] op;
        logic [3:0] bidx;
        logic [7:0] sh;
        logic [15:0] tick;
        logic [7:0] ackc;
        logic       nack;
        logic       scl;
        logic       sda;
        logic [7:0] rx;
        logic       miss;
    } seq_state_t;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [TDATA_W-1:0]   s_tdata = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [TDATA_W-1:0]   m_tdata;
    logic                 cfg_wr_en = 1'b0;
    logic                 cfg_index = CFG_HALF_PERIOD;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    // Config as the block holds it; only changed while nothing is in flight
    logic [15:0] model_hp;
    logic [7:0]  model_aw;

    seq_state_t  plan_state;   // runs ahead while the stimulus is built
    seq_state_t  line_state;   // advanced at each accepted item
    item_t       ticks_pending[$];
    result_t     levels_due[$];
    item_t       offer;

    int unsigned items_queued = 0;
    int unsigned items_taken = 0;
    int unsigned results_seen = 0;
    int unsigned errors = 0;
    int unsigned send_gap = 0;
    int unsigned rcv_gap = 0;
    int unsigned busy_noise_pct = 25;
    bit          gaps_on = 1'b1;

    // Long receiver hold-off, counted here on its own
    logic        hold_armed = 1'b0;
    logic        hold_done = 1'b0;
    int unsigned hold_left = 0;

    i2c_bitbang_master dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 aclk = ~aclk;

    // Entering a phase sets its line levels and restarts the tick count
    function automatic void phase_enter(inout seq_state_t m, input phase_t nxt);
        m.ph = nxt;
        m.tick = '0;
        case (nxt)
            PH_STA_A: m.sda = 1'b1;
            PH_STA_B: begin m.scl = 1'b1; m.sda = 1'b1; end
            PH_STA_C: begin m.scl = 1'b1; m.sda = 1'b0; end
            PH_STA_D: begin m.scl = 1'b0; m.sda = 1'b0; end
            PH_SP_A: begin m.scl = 1'b0; m.sda = 1'b0; end
            PH_SP_B: begin m.scl = 1'b1; m.sda = 1'b0; end
            PH_SP_C: begin m.scl = 1'b1; m.sda = 1'b1; end
            PH_BIT_LOW: begin
                m.scl = 1'b0;
                m.sda = (m.op == OP_WRITE) ? m.sh[7] : 1'b1;
            end
            PH_BIT_HIGH: m.scl = 1'b1;
            PH_NINE_LOW: begin
                m.scl = 1'b0;
                m.sda = (m.op == OP_WRITE) ? 1'b1 : m.nack;
            end
            PH_NINE_HIGH: begin m.scl = 1'b1; m.ackc = '0; end
            PH_END: begin m.scl = 1'b0; m.sda = 1'b1; end
            default: ;
        endcase
    endfunction

    // One tick of the sequencer; returns the levels and flags after it
    function automatic result_t bus_tick(inout seq_state_t m, input item_t it,
                                         input logic [15:0] hp, input logic [7:0] aw);
        result_t r;
        logic    done;
        done = 1'b0;
        if (m.ph == PH_IDLE) begin
            if (it.action >= OP_START && it.action <= OP_READ) begin
                m.op = it.action;
                m.bidx = '0;
                case (it.action)
                    OP_START: phase_enter(m, PH_STA_A);
                    OP_STOP:  phase_enter(m, PH_SP_A);
                    OP_WRITE: begin
                        m.sh = it.tx_byte;
                        m.miss = 1'b0;
                        phase_enter(m, PH_BIT_LOW);
                    end
                    default: begin
                        m.sh = '0;
                        m.nack = it.send_nack;
                        phase_enter(m, PH_BIT_LOW);
                    end
                endcase
            end
        end else if (m.ph == PH_NINE_HIGH && m.op == OP_WRITE) begin
            // ACK poll: ends on SDA low, or flags a miss and runs a stop
            if (!it.sda_in) begin
                phase_enter(m, PH_END);
            end else begin
                m.ackc = m.ackc + 8'd1;
                if (m.ackc >= aw) begin
                    m.miss = 1'b1;
                    phase_enter(m, PH_SP_A);
                end
            end
        end else begin
            m.tick = m.tick + 16'd1;
            if (m.tick >= hp) begin
                case (m.ph)
                    PH_STA_A:    phase_enter(m, PH_STA_B);
                    PH_STA_B:    phase_enter(m, PH_STA_C);
                    PH_STA_C:    phase_enter(m, PH_STA_D);
                    PH_SP_A:     phase_enter(m, PH_SP_B);
                    PH_SP_B:     phase_enter(m, PH_SP_C);
                    PH_BIT_LOW:  phase_enter(m, PH_BIT_HIGH);
                    PH_BIT_HIGH: begin
                        // reads shift in SDA on the last high tick
                        if (m.op == OP_READ) m.sh = {m.sh[6:0], it.sda_in};
                        else m.sh = {m.sh[6:0], 1'b0};
                        m.bidx = m.bidx + 4'd1;
                        if (m.bidx >= 4'd8) phase_enter(m, PH_NINE_LOW);
                        else phase_enter(m, PH_BIT_LOW);
                    end
                    PH_NINE_LOW:  phase_enter(m, PH_NINE_HIGH);
                    PH_NINE_HIGH: phase_enter(m, PH_END);
                    PH_END: begin
                        if (m.op == OP_READ) m.rx = m.sh;
                        m.ph = PH_IDLE;
                        m.tick = '0;
                        done = 1'b1;
                    end
                    default: begin
                        // last step of a start or a stop
                        m.ph = PH_IDLE;
                        m.tick = '0;
                        done = 1'b1;
                    end
                endcase
            end
        end
        r.scl_out = m.scl;
        r.sda_out = m.sda;
        r.busy_res = (m.ph != PH_IDLE);
        r.done_res = done;
        r.rx_byte = m.rx;
        r.ack_missing = m.miss;
        return r;
    endfunction

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(99);
        if (!gaps_on) return 0;
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(3, 1);
        if (r < 98) return $urandom_range(12, 4);
        return $urandom_range(60, 20);
    endfunction

    function automatic slave_ack_t pick_ack();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 70) return ACK_NOW;
        if (r < 90) return ACK_LATE;
        return ACK_NEVER;
    endfunction

    task automatic check_field(input string name, input logic [7:0] want,
                               input logic [7:0] got);
        if (want !== got) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            errors++;
        end
    endtask

    // Queue one tick and advance the look-ahead model with it
    task automatic push_item(input item_t it);
        void'(bus_tick(plan_state, it, model_hp, model_aw));
        ticks_pending.push_back(it);
        items_queued++;
    endtask

    // Issue one command, then tick until it completes. While busy some ticks
    // carry stray commands, which must be ignored - the completion tick too.
    task automatic run_cmd(input logic [2:0] act, input logic [7:0] tx,
                           input logic nack, input slave_ack_t ack_mode,
                           input sda_drive_t sda_mode);
        item_t it;
        it.action = act;
        it.tx_byte = tx;
        it.send_nack = nack;
        it.sda_in = 1'($urandom_range(1));
        push_item(it);
        while (plan_state.ph != PH_IDLE) begin
            it.tx_byte = 8'($urandom_range(255));
            it.send_nack = 1'($urandom_range(1));
            it.action = ($urandom_range(99) < busy_noise_pct) ?
                        3'($urandom_range(7)) : OP_NONE;
            if (plan_state.ph == PH_NINE_HIGH && plan_state.op == OP_WRITE) begin
                case (ack_mode)
                    ACK_NOW:  it.sda_in = 1'b0;
                    ACK_LATE: it.sda_in = ($urandom_range(2) != 0);
                    default:  it.sda_in = 1'b1;
                endcase
            end else begin
                case (sda_mode)
                    SDA_LOW:  it.sda_in = 1'b0;
                    SDA_HIGH: it.sda_in = 1'b1;
                    default:  it.sda_in = 1'($urandom_range(1));
                endcase
            end
            push_item(it);
        end
    endtask

    // Ticks on an idle bus: no command or one of the spare codes
    task automatic idle_ticks(input int unsigned n);
        item_t it;
        repeat (n) begin
            it.action = $urandom_range(1) ? OP_NONE :
                        3'($urandom_range(ACT_SPARE_HI, ACT_SPARE_LO));
            it.tx_byte = 8'($urandom_range(255));
            it.send_nack = 1'($urandom_range(1));
            it.sda_in = 1'($urandom_range(1));
            push_item(it);
        end
    endtask

    // Mostly well-formed transfers (start, address, bytes, stop) with random
    // content; about one in five is a run of arbitrary commands.
    task automatic random_traffic(input int unsigned target);
        int unsigned mark;
        int unsigned nbytes;
        mark = items_queued;
        while (items_queued - mark < target) begin
            if ($urandom_range(4) == 0) begin
                repeat ($urandom_range(4, 1)) begin
                    run_cmd(3'($urandom_range(OP_READ, OP_START)), 8'($urandom_range(255)),
                            1'($urandom_range(1)), pick_ack(), SDA_RAND);
                    idle_ticks($urandom_range(2));
                end
            end else begin
                run_cmd(OP_START, 8'($urandom_range(255)), 1'b0, ACK_NOW, SDA_RAND);
                run_cmd(OP_WRITE, 8'($urandom_range(255)), 1'b0, pick_ack(), SDA_RAND);
                nbytes = $urandom_range(3);
                for (int unsigned k = 0; k < nbytes; k++) begin
                    if ($urandom_range(1))
                        run_cmd(OP_WRITE, 8'($urandom_range(255)), 1'b0, pick_ack(), SDA_RAND);
                    else
                        run_cmd(OP_READ, 8'($urandom_range(255)),
                                (k + 1 == nbytes) ? ($urandom_range(9) < 7) : 1'($urandom_range(1)),
                                ACK_NOW, SDA_RAND);
                end
                run_cmd(OP_STOP, 8'($urandom_range(255)), 1'b0, ACK_NOW, SDA_RAND);
            end
            idle_ticks($urandom_range(3));
        end
    endtask

    // Wait until every queued tick is taken and answered, then let the
    // two-register pipeline settle.
    task automatic drain();
        while (items_taken != items_queued || results_seen != items_queued)
            @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // Both registers, on consecutive edges; called at a rising edge
    task automatic set_config(input logic [15:0] hp, input logic [7:0] aw);
        cfg_wr_en <= 1'b1;
        cfg_index <= CFG_HALF_PERIOD;
        cfg_data  <= hp;
        @(posedge aclk);
        cfg_index <= CFG_ACK_WAIT;
        cfg_data  <= {8'd0, aw};
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        model_hp = hp;
        model_aw = aw;
    endtask

    // Driver: offers queued ticks, predicts each one as it is accepted
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            send_gap = 0;
        end else begin
            if (s_tvalid && s_tready) begin
                levels_due.push_back(bus_tick(line_state, offer, model_hp, model_aw));
                items_taken++;
            end
            if (!s_tvalid || s_tready) begin
                if (send_gap != 0) begin
                    send_gap--;
                    s_tvalid <= 1'b0;
                end else if (ticks_pending.size() != 0) begin
                    offer = ticks_pending.pop_front();
                    // [2:0] action, [10:3] tx_byte, [11] send_nack, [12] sda_in
                    s_tdata <= {3'b000, offer.sda_in, offer.send_nack,
                                offer.tx_byte, offer.action};
                    s_tvalid <= 1'b1;
                    send_gap = pick_gap();
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            hold_left <= 0;
            hold_done <= 1'b0;
        end else if (hold_armed && !hold_done) begin
            hold_left <= 400;
            hold_done <= 1'b1;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // Monitor: compares each accepted result with the oldest prediction
    always @(posedge aclk) begin : result_side
        result_t got;
        result_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
            rcv_gap = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                // [0] scl, [1] sda, [2] busy, [3] done, [11:4] rx_byte, [12] ack_missing
                got.scl_out = m_tdata[0];
                got.sda_out = m_tdata[1];
                got.busy_res = m_tdata[2];
                got.done_res = m_tdata[3];
                got.rx_byte = m_tdata[11:4];
                got.ack_missing = m_tdata[12];
                if (levels_due.size() == 0) begin
                    $error("result with nothing predicted: %0h", m_tdata);
                    errors++;
                end else begin
                    want = levels_due.pop_front();
                    check_field("scl_out", want.scl_out, got.scl_out);
                    check_field("sda_out", want.sda_out, got.sda_out);
                    check_field("busy_res", want.busy_res, got.busy_res);
                    check_field("done_res", want.done_res, got.done_res);
                    check_field("rx_byte", want.rx_byte, got.rx_byte);
                    check_field("ack_missing", want.ack_missing, got.ack_missing);
                end
                results_seen++;
            end
            if (rcv_gap != 0) rcv_gap--;
            else if ($urandom_range(99) < 15) rcv_gap = pick_gap();
            m_tready <= (rcv_gap == 0) && (hold_left == 0);
        end
    end

    initial begin
        int unsigned random_items;
        int unsigned mark;
        logic [15:0] hp_pick;
        logic [7:0]  aw_pick;
        bit          first_pass;

        plan_state.ph = PH_IDLE;
        plan_state.op = '0;
        plan_state.bidx = '0;
        plan_state.sh = '0;
        plan_state.tick = '0;
        plan_state.ackc = '0;
        plan_state.nack = 1'b0;
        plan_state.scl = 1'b1;
        plan_state.sda = 1'b1;
        plan_state.rx = '0;
        plan_state.miss = 1'b0;
        line_state = plan_state;
        model_hp = HALF_PERIOD_RST;
        model_aw = ACK_WAIT_RST;

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        // Reset timing: idle ticks with spare codes, then a stop
        push_item('{action: OP_NONE, tx_byte: 8'hFF, send_nack: 1'b1, sda_in: 1'b1});
        push_item('{action: ACT_SPARE_LO, tx_byte: 8'h00, send_nack: 1'b0, sda_in: 1'b0});
        push_item('{action: 3'd6, tx_byte: 8'hFF, send_nack: 1'b0, sda_in: 1'b1});
        push_item('{action: ACT_SPARE_HI, tx_byte: 8'h00, send_nack: 1'b1, sda_in: 1'b0});
        run_cmd(OP_STOP, 8'h00, 1'b0, ACK_NOW, SDA_RAND);
        drain();

        // Fastest clock, longest ACK wait: a full set of commands
        set_config(16'd1, 8'd255);
        run_cmd(OP_START, 8'h00, 1'b0, ACK_NOW, SDA_RAND);
        run_cmd(OP_WRITE, 8'hFF, 1'b0, ACK_NOW, SDA_RAND);
        run_cmd(OP_WRITE, 8'h00, 1'b0, ACK_NEVER, SDA_RAND);  // miss, auto stop
        run_cmd(OP_START, 8'h00, 1'b0, ACK_NOW, SDA_RAND);
        run_cmd(OP_WRITE, 8'h5A, 1'b1, ACK_LATE, SDA_RAND);
        run_cmd(OP_READ, 8'h00, 1'b0, ACK_NOW, SDA_HIGH);
        busy_noise_pct = 100;   // a stray command on every busy tick
        run_cmd(OP_READ, 8'hFF, 1'b1, ACK_NOW, SDA_LOW);
        busy_noise_pct = 25;
        run_cmd(OP_STOP, 8'h00, 1'b0, ACK_NOW, SDA_RAND);
        run_cmd(OP_STOP, 8'hFF, 1'b1, ACK_NOW, SDA_RAND);    // stop on idle bus
        run_cmd(OP_WRITE, 8'h81, 1'b0, ACK_NOW, SDA_RAND);   // write on idle bus
        run_cmd(OP_READ, 8'h3C, 1'b1, ACK_NOW, SDA_RAND);    // read on idle bus
        drain();

        // Zero in both registers acts as one tick and one poll
        set_config(16'd0, 8'd0);
        run_cmd(OP_START, 8'h00, 1'b0, ACK_NOW, SDA_RAND);
        run_cmd(OP_WRITE, 8'hC3, 1'b0, ACK_NEVER, SDA_RAND);
        run_cmd(OP_READ, 8'h00, 1'b0, ACK_NOW, SDA_RAND);
        run_cmd(OP_STOP, 8'h00, 1'b0, ACK_NOW, SDA_RAND);
        drain();

        // Slower clock: one stop, no idling so it stays short
        set_config(16'd40, 8'd1);
        gaps_on = 1'b0;
        run_cmd(OP_STOP, 8'h00, 1'b0, ACK_NOW, SDA_RAND);
        drain();

        // Random traffic over a spread of settings, mostly fast clocks
        random_items = 0;
        first_pass = 1'b1;
        while (random_items < 500) begin
            case ($urandom_range(19))
                0:       hp_pick = 16'($urandom_range(12, 6));
                1, 2, 3, 4, 5: hp_pick = 16'($urandom_range(5, 3));
                default: hp_pick = 16'($urandom_range(2, 1));
            endcase
            case ($urandom_range(9))
                0:       aw_pick = 8'($urandom_range(255, 31));
                1, 2, 3: aw_pick = 8'($urandom_range(30, 7));
                default: aw_pick = 8'($urandom_range(6, 1));
            endcase
            set_config(hp_pick, aw_pick);
            gaps_on = first_pass || ($urandom_range(3) != 0);
            mark = items_queued;
            random_traffic(250);
            if (first_pass) hold_armed <= 1'b1;  // receiver backs off for a while
            first_pass = 1'b0;
            drain();
            random_items += items_queued - mark;
        end

        if (errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    // Hang guard, several times the slowest legal run
    initial begin
        #50_000_000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule
